[hdl/hofcm_pkg.sv]
// Package for the heading outlier filter: widths, codes, state and command types,
// and the CORDIC arctangent table.
// No dependencies.
package hofcm_pkg;

    localparam int HIST_DEPTH_DEF  = 5;
    localparam int ANGLE_BITS_DEF  = 16;
    localparam int CORDIC_ITERS    = 16;
    localparam int IT_W            = 4;
    localparam int XW              = 42;
    localparam int ZW              = 34;
    localparam int VEL_W           = 24;
    localparam int SUM_W           = 24;
    localparam logic signed [15:0] INV_GAIN = 16'sd19898;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_STOP   = 2'd2;

    localparam logic [1:0] REG_OUTLIER_THR = 2'd0;
    localparam logic [1:0] REG_OUTLIER_LIM = 2'd1;
    localparam logic [1:0] REG_LOW_SPEED   = 2'd2;

    localparam logic [15:0] OUTLIER_THR_RST = 16'd3641;
    localparam logic [3:0]  OUTLIER_LIM_RST = 4'd3;
    localparam logic [14:0] LOW_SPEED_RST   = 15'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_VROT, ST_VWAIT, ST_SEL, ST_AWAIT, ST_FILT,
        ST_MRD, ST_MROT, ST_MAWAIT, ST_OP, ST_FIN
    } state_t;

    typedef enum logic [1:0] {SRC_VEL, SRC_ATAN_V, SRC_UNIT, SRC_ATAN_S} csrc_t;

    typedef struct packed {
        logic  load_in;
        logic  cord_start;
        csrc_t cord_src;
        logic  cap_vel;
        logic  pick;
        logic  cap_sample;
        logic  filter;
        logic  walk_step;
        logic  acc;
        logic  mean_direct;
        logic  cap_mean;
        logic  apply_op;
        logic  emit;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       cord_done;
        logic       slow;
        logic       vzero;
        logic       walk_done;
        logic       entry_valid;
        logic       any_valid;
        logic       sum_zero;
        logic       out_free;
    } dp_stat_t;

    function automatic logic [31:0] atan_tab(input logic [IT_W-1:0] i);
        logic [31:0] r;
        case (i)
            4'd0:    r = 32'd536870912;
            4'd1:    r = 32'd316933406;
            4'd2:    r = 32'd167458907;
            4'd3:    r = 32'd85004756;
            4'd4:    r = 32'd42667331;
            4'd5:    r = 32'd21354465;
            4'd6:    r = 32'd10679838;
            4'd7:    r = 32'd5340245;
            4'd8:    r = 32'd2670163;
            4'd9:    r = 32'd1335087;
            4'd10:   r = 32'd667544;
            4'd11:   r = 32'd333772;
            4'd12:   r = 32'd166886;
            4'd13:   r = 32'd83443;
            4'd14:   r = 32'd41722;
            default: r = 32'd20861;
        endcase
        return r;
    endfunction

endpackage

[hdl/hofcm_cordic.sv]
// Iterative CORDIC, one micro-rotation per cycle, rotation and vectoring modes.
// Depends on hofcm_pkg.
module hofcm_cordic
    import hofcm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic                 vec_mode,
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  logic [31:0]          z_in,
    output logic                 done,
    output logic signed [XW-1:0] x_out,
    output logic signed [XW-1:0] y_out,
    output logic [31:0]          ang_out
);

    localparam logic signed [ZW-1:0] QTR  = ZW'(64'sd1073741824);
    localparam logic signed [ZW-1:0] HALF = ZW'(64'sd2147483648);

    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [31:0]          base_reg, base_next;
    logic                 vec_reg, run_reg, done_reg;
    logic [IT_W-1:0]      iter_reg;

    logic signed [ZW-1:0] zs, t;
    logic signed [XW-1:0] dx, dy;
    logic                 up;

    always_comb begin
        zs = {{(ZW-32){z_in[31]}}, z_in};
        t  = {{(ZW-32){1'b0}}, atan_tab(iter_reg)};
        dx = y_reg >>> iter_reg;
        dy = x_reg >>> iter_reg;
        up = vec_reg ? y_reg[XW-1] : !z_reg[ZW-1];
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        base_next = base_reg;
        if (start) begin
            x_next = x_in;
            y_next = y_in;
            z_next = zs;
            base_next = 32'd0;
            if (vec_mode) begin
                z_next = '0;
                if (x_in[XW-1]) begin
                    x_next = -x_in;
                    y_next = -y_in;
                    base_next = 32'h8000_0000;
                end
            end else if (zs > QTR) begin
                z_next = zs - HALF;
                x_next = -x_in;
            end else if (zs < -QTR) begin
                z_next = zs + HALF;
                x_next = -x_in;
            end
        end else if (run_reg) begin
            if (up) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - t;
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + t;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        base_reg <= base_next;
        if (start) vec_reg <= vec_mode;
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg  <= 1'b1;
                iter_reg <= '0;
            end else if (run_reg) begin
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == IT_W'(CORDIC_ITERS - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign ang_out = base_reg + z_reg[31:0];

endmodule

[hdl/hofcm_dp.sv]
// Datapath: config registers, heading history ring, outlier filter, mean sums,
// output register. Depends on hofcm_pkg and hofcm_cordic.
module hofcm_dp
    import hofcm_pkg::*;
#(
    parameter int HISTORY_DEPTH = HIST_DEPTH_DEF,
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic [1:0]  in_op,
    input  logic [15:0] in_speed,
    input  logic [15:0] in_heading,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [15:0] m_tdata,
    output logic [2:0]  m_tuser
);

    localparam int AB  = ANGLE_BITS;
    localparam int SH  = 32 - AB;
    localparam int D   = HISTORY_DEPTH;
    localparam int IW  = (D > 1) ? $clog2(D) : 1;
    localparam int FW  = $clog2(D + 1);
    localparam logic [AB-1:0] HALF_ANG = AB'(1) << (AB - 1);

    logic [15:0] thr_reg;
    logic [3:0]  lim_reg;
    logic [14:0] lst_reg;

    logic [1:0]  op_reg;
    logic [15:0] speed_reg, hdg_reg;

    logic [AB:0]      hist_reg [D];
    logic [IW-1:0]    head_reg, head_next, walk_idx_reg;
    logic [FW-1:0]    fill_reg, fill_next, walk_k_reg;
    logic             mean_v_reg;
    logic [AB-1:0]    mean_a_reg;
    logic [3:0]       cnt_reg;
    logic             smp_v_reg;
    logic [AB-1:0]    smp_a_reg;
    logic signed [VEL_W-1:0] vx_reg, vy_reg;
    logic             slow_reg, vzero_reg;
    logic signed [SUM_W-1:0] sx_reg, sy_reg;
    logic             any_reg, held_reg, cleared_reg;
    logic             out_v_reg;
    logic [15:0]      out_d_reg;
    logic [2:0]       out_u_reg;

    logic                 c_vec;
    logic signed [XW-1:0] c_x, c_y, co_x, co_y;
    logic [31:0]          c_z, co_ang;
    logic                 c_done;
    logic signed [31:0]   prod;
    logic [AB:0]          rd;
    logic [31:0]          hdg32;

    logic signed [XW-1:0] rx, ry;
    logic signed [VEL_W-1:0] vx_c, vy_c, ax_c, ay_c;

    logic [AB-1:0] d_ang, mag;
    logic          f_held, f_clr, is_out;
    logic [AB:0]   f_s;
    logic [3:0]    f_cnt;
    logic [IW-1:0] head_eff;
    logic [FW-1:0] fill_eff;

    function automatic logic [31:0] to_int(input logic [AB-1:0] a);
        return {a, {SH{1'b0}}};
    endfunction

    function automatic logic [AB-1:0] to_ext(input logic [31:0] a);
        logic [31:0] t;
        t = a + (32'd1 << (SH - 1));
        return t[31:SH];
    endfunction

    function automatic logic [IW-1:0] dec_idx(input logic [IW-1:0] i);
        return (i == '0) ? IW'(D - 1) : i - 1'b1;
    endfunction

    assign prod  = $signed(speed_reg) * INV_GAIN;
    assign hdg32 = {16'd0, hdg_reg};
    assign rd    = hist_reg[walk_idx_reg];

    always_comb begin
        c_vec = 1'b0;
        c_x   = '0;
        c_y   = '0;
        c_z   = '0;
        case (cmd.cord_src)
            SRC_VEL: begin
                c_x = {{(XW-32){prod[31]}}, prod};
                c_z = to_int(hdg32[AB-1:0]);
            end
            SRC_ATAN_V: begin
                c_vec = 1'b1;
                c_x = {{(XW-VEL_W-16){vx_reg[VEL_W-1]}}, vx_reg, 16'd0};
                c_y = {{(XW-VEL_W-16){vy_reg[VEL_W-1]}}, vy_reg, 16'd0};
            end
            SRC_UNIT: begin
                c_x = XW'(INV_GAIN);
                c_z = to_int(rd[AB-1:0]);
            end
            default: begin
                c_vec = 1'b1;
                c_x = {{(XW-SUM_W-16){sx_reg[SUM_W-1]}}, sx_reg, 16'd0};
                c_y = {{(XW-SUM_W-16){sy_reg[SUM_W-1]}}, sy_reg, 16'd0};
            end
        endcase
    end

    hofcm_cordic u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.cord_start),
        .vec_mode (c_vec),
        .x_in     (c_x),
        .y_in     (c_y),
        .z_in     (c_z),
        .done     (c_done),
        .x_out    (co_x),
        .y_out    (co_y),
        .ang_out  (co_ang)
    );

    // velocity rounding to Q8.8
    always_comb begin
        rx   = co_x + XW'(16384);
        ry   = co_y + XW'(16384);
        vx_c = rx[VEL_W+14:15];
        vy_c = ry[VEL_W+14:15];
        ax_c = vx_c[VEL_W-1] ? -vx_c : vx_c;
        ay_c = vy_c[VEL_W-1] ? -vy_c : vy_c;
    end

    // outlier filter
    always_comb begin
        d_ang    = smp_a_reg - mean_a_reg;
        mag      = (d_ang <= HALF_ANG) ? d_ang : -d_ang;
        is_out   = 32'(mag) > 32'(thr_reg);
        f_held   = 1'b0;
        f_clr    = 1'b0;
        f_s      = {smp_v_reg, smp_a_reg};
        f_cnt    = cnt_reg;
        if (smp_v_reg && mean_v_reg) begin
            if (is_out) begin
                if (cnt_reg > lim_reg) begin
                    f_cnt = '0;
                    f_clr = 1'b1;
                end else begin
                    if (cnt_reg != 4'd15) f_cnt = cnt_reg + 1'b1;
                    f_s    = {mean_v_reg, mean_a_reg};
                    f_held = 1'b1;
                end
            end else if (cnt_reg != '0) begin
                f_cnt = cnt_reg - 1'b1;
            end
        end
        head_eff  = f_clr ? '0 : head_reg;
        fill_eff  = f_clr ? '0 : fill_reg;
        head_next = (head_eff == IW'(D - 1)) ? '0 : head_eff + 1'b1;
        fill_next = (fill_eff == FW'(D)) ? fill_eff : fill_eff + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg    <= in_op;
            speed_reg <= in_speed;
            hdg_reg   <= in_heading;
        end
        if (cmd.cap_vel) begin
            vx_reg       <= vx_c;
            vy_reg       <= vy_c;
            walk_idx_reg <= dec_idx(head_reg);
        end
        if (cmd.filter) begin
            hist_reg[head_eff] <= f_s;
            walk_idx_reg <= head_eff;
        end else if (cmd.walk_step || cmd.acc) begin
            walk_idx_reg <= dec_idx(walk_idx_reg);
        end
        if (cmd.pick) begin
            if (slow_reg) begin
                smp_v_reg <= (fill_reg != '0) && rd[AB];
                smp_a_reg <= (fill_reg != '0) ? rd[AB-1:0] : '0;
            end else begin
                smp_v_reg <= 1'b1;
                smp_a_reg <= '0;
            end
        end
        if (cmd.cap_sample) begin
            smp_v_reg <= 1'b1;
            smp_a_reg <= to_ext(co_ang);
        end
        if (cmd.filter) begin
            sx_reg <= '0;
            sy_reg <= '0;
        end else if (cmd.acc) begin
            sx_reg <= sx_reg + co_x[SUM_W-1:0];
            sy_reg <= sy_reg + co_y[SUM_W-1:0];
        end
        if (cmd.emit) begin
            out_d_reg <= mean_v_reg ? 16'(32'(mean_a_reg)) : 16'd0;
            out_u_reg <= {cleared_reg, held_reg, mean_v_reg};
        end

        if (!aresetn) begin
            thr_reg     <= OUTLIER_THR_RST;
            lim_reg     <= OUTLIER_LIM_RST;
            lst_reg     <= LOW_SPEED_RST;
            head_reg    <= '0;
            fill_reg    <= '0;
            walk_k_reg  <= '0;
            mean_v_reg  <= 1'b0;
            mean_a_reg  <= '0;
            cnt_reg     <= '0;
            slow_reg    <= 1'b0;
            vzero_reg   <= 1'b0;
            any_reg     <= 1'b0;
            held_reg    <= 1'b0;
            cleared_reg <= 1'b0;
            out_v_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_OUTLIER_THR: thr_reg <= cfg_wdata;
                    REG_OUTLIER_LIM: lim_reg <= cfg_wdata[3:0];
                    REG_LOW_SPEED:   lst_reg <= cfg_wdata[14:0];
                    default: ;
                endcase
            end
            if (cmd.load_in) begin
                held_reg    <= 1'b0;
                cleared_reg <= 1'b0;
            end
            if (cmd.cap_vel) begin
                slow_reg  <= (ax_c < VEL_W'(lst_reg)) && (ay_c < VEL_W'(lst_reg));
                vzero_reg <= (vx_c == '0) && (vy_c == '0);
            end
            if (cmd.filter) begin
                cnt_reg     <= f_cnt;
                held_reg    <= f_held;
                cleared_reg <= f_clr;
                head_reg    <= head_next;
                fill_reg    <= fill_next;
                walk_k_reg  <= '0;
                any_reg     <= 1'b0;
            end else if (cmd.walk_step || cmd.acc) begin
                walk_k_reg <= walk_k_reg + 1'b1;
            end
            if (cmd.acc) any_reg <= 1'b1;
            if (cmd.mean_direct) begin
                mean_v_reg <= any_reg;
                mean_a_reg <= '0;
            end
            if (cmd.cap_mean) begin
                mean_v_reg <= 1'b1;
                mean_a_reg <= to_ext(co_ang);
            end
            if (cmd.apply_op) begin
                if (op_reg == OP_START) begin
                    mean_v_reg <= 1'b0;
                    mean_a_reg <= '0;
                end else if (op_reg == OP_STOP) begin
                    head_reg    <= '0;
                    fill_reg    <= '0;
                    cleared_reg <= 1'b1;
                end
            end
            if (cmd.emit) out_v_reg <= 1'b1;
            else if (m_tready) out_v_reg <= 1'b0;
        end
    end

    always_comb begin
        stat.op          = op_reg;
        stat.cord_done   = c_done;
        stat.slow        = slow_reg;
        stat.vzero       = vzero_reg;
        stat.walk_done   = (walk_k_reg == fill_reg);
        stat.entry_valid = rd[AB];
        stat.any_valid   = any_reg;
        stat.sum_zero    = (sx_reg == '0) && (sy_reg == '0);
        stat.out_free    = !out_v_reg || m_tready;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;
    assign m_tuser  = out_u_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(D)) else $error("history fill beyond depth");
    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(head_reg) < D) else $error("history head out of range");
    a_held_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg |-> !(out_u_reg[1] && out_u_reg[2]))
        else $error("held and history reset together");
    a_inv_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_v_reg && !out_u_reg[0]) |-> (out_d_reg == 16'd0))
        else $error("invalid heading with nonzero angle");
`endif

endmodule

[hdl/hofcm_ctrl.sv]
// Controller state machine: sequences velocity rotation, heading pick,
// outlier filter, history walk and mean arctangent. Depends on hofcm_pkg.
module hofcm_ctrl
    import hofcm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic [1:0] in_op,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.cord_src = SRC_VEL;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = (in_op == OP_SAMPLE) ? ST_VROT : ST_OP;
                end
            end
            ST_VROT: begin
                cmd.cord_start = 1'b1;
                cmd.cord_src   = SRC_VEL;
                state_next     = ST_VWAIT;
            end
            ST_VWAIT: begin
                if (stat.cord_done) begin
                    cmd.cap_vel = 1'b1;
                    state_next  = ST_SEL;
                end
            end
            ST_SEL: begin
                if (stat.slow || stat.vzero) begin
                    cmd.pick   = 1'b1;
                    state_next = ST_FILT;
                end else begin
                    cmd.cord_start = 1'b1;
                    cmd.cord_src   = SRC_ATAN_V;
                    state_next     = ST_AWAIT;
                end
            end
            ST_AWAIT: begin
                if (stat.cord_done) begin
                    cmd.cap_sample = 1'b1;
                    state_next     = ST_FILT;
                end
            end
            ST_FILT: begin
                cmd.filter = 1'b1;
                state_next = ST_MRD;
            end
            ST_MRD: begin
                if (stat.walk_done) begin
                    if (stat.any_valid && !stat.sum_zero) begin
                        cmd.cord_start = 1'b1;
                        cmd.cord_src   = SRC_ATAN_S;
                        state_next     = ST_MAWAIT;
                    end else begin
                        cmd.mean_direct = 1'b1;
                        state_next      = ST_FIN;
                    end
                end else if (stat.entry_valid) begin
                    cmd.cord_start = 1'b1;
                    cmd.cord_src   = SRC_UNIT;
                    state_next     = ST_MROT;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_MROT: begin
                if (stat.cord_done) begin
                    cmd.acc    = 1'b1;
                    state_next = ST_MRD;
                end
            end
            ST_MAWAIT: begin
                if (stat.cord_done) begin
                    cmd.cap_mean = 1'b1;
                    state_next   = ST_FIN;
                end
            end
            ST_OP: begin
                cmd.apply_op = 1'b1;
                state_next   = ST_FIN;
            end
            ST_FIN: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_one_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cord_start |=> !cmd.cord_start) else $error("back to back CORDIC start");
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.out_free) else $error("emit into full output register");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in |=> !s_tready) else $error("item taken while busy");
`endif

endmodule

[hdl/heading_outlier_filter_circular_mean.sv]
// Top level of the heading outlier filter with circular mean.
// Depends on hofcm_pkg, hofcm_ctrl, hofcm_dp (and hofcm_cordic below it).
//
// Usage:
//   Slave channel s_*: one item per operation. s_tuser carries the op
//   (sample, start, stop); s_tdata carries speed (Q8.8) and travel heading.
//   Master channel m_*: one result item per input item, m_tdata the mean
//   heading, m_tuser the valid, held and history-reset flags.
//   Config: cfg_we/cfg_addr/cfg_wdata write the outlier threshold, outlier
//   limit and low-speed threshold; write only while the block is idle.
// Sequencing:
//   Each sample uses the single 16-step CORDIC, shared by velocity rotation,
//   heading arctangent, per-entry unit vectors for valid history entries and
//   the mean arctangent; a slow or zero-velocity sample skips the heading
//   arctangent. One item is processed at a time; s_tready is high only when idle.
// Reset (aresetn low, synchronous): config returns to defaults, history
//   empty, last mean heading invalid, outlier count zero, output empty.
// Stall: the result sits in an output register; the next item is accepted
//   while it waits, and its own result waits until that register frees.
module heading_outlier_filter_circular_mean
    import hofcm_pkg::*;
#(
    parameter int HISTORY_DEPTH = HIST_DEPTH_DEF,
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // speed[15:0], travel_heading[31:16]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // mean_heading[15:0]
    output logic [2:0]  m_tuser    // heading_valid[0], sample_held[1], history_reset[2]
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    hofcm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_op    (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    hofcm_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .ANGLE_BITS    (ANGLE_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_op      (s_tuser),
        .in_speed   (s_tdata[15:0]),
        .in_heading (s_tdata[31:16]),
        .cmd        (cmd),
        .stat       (stat),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

[verif/tb.sv]
// Testbench for heading_outlier_filter_circular_mean: directed table, then random items
// in phases over register settings, checked against an in-bench heading predictor.
// Depends on hofcm_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb;
    import hofcm_pkg::*;

    localparam int  DEPTH      = 5;
    localparam int  LIMIT      = 2000000;
    localparam int  DRAIN      = 200;
    localparam int  RAND_ITEMS = 1530;
    localparam longint ATAN_T [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861
    };
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct {
        logic [15:0] mean;
        logic        valid;
        logic        held;
        logic        hreset;
    } heading_res_t;

    typedef struct {
        logic [1:0]   op;
        logic [15:0]  speed;
        logic [15:0]  hdg;
        bit           typed;
        heading_res_t res;
    } vec_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;

    heading_res_t pending_q[$];
    int  errors = 0;
    int  cycles = 0;
    int  src_idle = 0;
    int  snk_idle = 0;
    bit  hold_req = 0;

    // predictor state
    logic [15:0] p_thr;
    logic [3:0]  p_lim;
    logic [14:0] p_low;
    logic        hist_v [DEPTH];
    logic [15:0] hist_a [DEPTH];
    int          hist_fill, hist_head, out_cnt;
    logic        mean_v;
    logic [15:0] mean_a;

    heading_outlier_filter_circular_mean DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void rotate_vec(input longint x0, input logic [31:0] a,
                                       output longint ox, output longint oy);
        longint z, x, y, dx, dy;
        z = longint'($signed(a));
        x = x0;
        y = 0;
        if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648;
            x = -x;
        end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648;
            x = -x;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_T[i];
            end else begin
                x += dx; y -= dy; z += ATAN_T[i];
            end
        end
        ox = x;
        oy = y;
    endfunction

    function automatic logic [31:0] vec_angle(input longint yi, input longint xi);
        longint x, y, z, dx, dy;
        logic [31:0] base;
        if (xi == 0 && yi == 0) return 32'd0;
        x = xi * 65536;
        y = yi * 65536;
        z = 0;
        base = 32'd0;
        if (x < 0) begin
            x = -x; y = -y; base = 32'h8000_0000;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += ATAN_T[i];
            end else begin
                x -= dx; y += dy; z -= ATAN_T[i];
            end
        end
        return base + z[31:0];
    endfunction

    function automatic logic [15:0] round_angle(input logic [31:0] a);
        logic [63:0] t;
        t = {32'd0, a} + 64'd32768;
        return t[31:16];
    endfunction

    function automatic void clear_history();
        hist_fill = 0;
        hist_head = 0;
    endfunction

    function automatic void reset_model();
        p_thr = OUTLIER_THR_RST;
        p_lim = OUTLIER_LIM_RST;
        p_low = LOW_SPEED_RST;
        for (int i = 0; i < DEPTH; i++) begin
            hist_v[i] = 0;
            hist_a[i] = '0;
        end
        clear_history();
        mean_v = 0;
        mean_a = '0;
        out_cnt = 0;
    endfunction

    function automatic void update_mean();
        longint sx, sy, cx, cy;
        int n, idx;
        sx = 0; sy = 0; n = 0;
        for (int k = 0; k < hist_fill; k++) begin
            idx = (hist_head + 2 * DEPTH - 1 - k) % DEPTH;
            if (hist_v[idx]) begin
                rotate_vec(19898, {hist_a[idx], 16'd0}, cx, cy);
                sx += cx;
                sy += cy;
                n++;
            end
        end
        mean_v = (n != 0);
        mean_a = (n != 0) ? round_angle(vec_angle(sy, sx)) : 16'd0;
    endfunction

    function automatic heading_res_t predict_heading(input logic [1:0] op,
                                                     input logic [15:0] spd,
                                                     input logic [15:0] hdg);
        heading_res_t r;
        longint x, y, vx, vy, ax, ay;
        logic sv;
        logic [15:0] sa, d;
        int mag;
        r.held = 0;
        r.hreset = 0;
        if (op == OP_SAMPLE) begin
            rotate_vec(longint'($signed(spd)) * 19898, {hdg, 16'd0}, x, y);
            vx = (x + 16384) >>> 15;
            vy = (y + 16384) >>> 15;
            ax = vx < 0 ? -vx : vx;
            ay = vy < 0 ? -vy : vy;
            sv = 0;
            sa = '0;
            if (ax < longint'(p_low) && ay < longint'(p_low)) begin
                if (hist_fill > 0) begin
                    sv = hist_v[(hist_head + DEPTH - 1) % DEPTH];
                    sa = hist_a[(hist_head + DEPTH - 1) % DEPTH];
                end
            end else begin
                sv = 1;
                sa = round_angle(vec_angle(vy, vx));
            end
            if (sv && mean_v) begin
                d = sa - mean_a;
                mag = (d <= 16'h8000) ? int'(d) : 65536 - int'(d);
                if (mag > int'(p_thr)) begin
                    if (out_cnt > int'(p_lim)) begin
                        out_cnt = 0;
                        clear_history();
                        r.hreset = 1;
                    end else begin
                        if (out_cnt < 15) out_cnt++;
                        sa = mean_a;
                        r.held = 1;
                    end
                end else if (out_cnt > 0) begin
                    out_cnt--;
                end
            end
            hist_v[hist_head] = sv;
            hist_a[hist_head] = sa;
            hist_head = (hist_head + 1) % DEPTH;
            if (hist_fill < DEPTH) hist_fill++;
            update_mean();
        end else if (op == OP_START) begin
            mean_v = 0;
            mean_a = '0;
        end else if (op == OP_STOP) begin
            clear_history();
            r.hreset = 1;
        end
        r.mean = mean_v ? mean_a : 16'd0;
        r.valid = mean_v;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        errors++;
        $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_we = 1;
        cfg_addr = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 0;
        case (idx)
            REG_OUTLIER_THR: p_thr = val;
            REG_OUTLIER_LIM: p_lim = val[3:0];
            REG_LOW_SPEED:   p_low = val[14:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic send_item(input logic [1:0] op, input logic [15:0] spd,
                             input logic [15:0] hdg, input bit typed,
                             input heading_res_t want);
        heading_res_t r;
        @(negedge aclk);
        if ($urandom_range(99) < src_idle) begin
            s_tvalid = 0;
            repeat ($urandom_range(8, 1)) @(negedge aclk);
        end
        s_tvalid = 1;
        s_tuser = op;
        s_tdata = {hdg, spd};
        do @(posedge aclk); while (!s_tready);
        r = predict_heading(op, spd, hdg);
        pending_q.push_back(typed ? want : r);
    endtask

    // result checking
    always @(posedge aclk) begin
        heading_res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                errors++;
                $display("[%0t] result with nothing expected", $time);
            end else begin
                e = pending_q.pop_front();
                if (m_tdata !== e.mean) report_mismatch("mean_heading", m_tdata, e.mean);
                if (m_tuser[0] !== e.valid)
                    report_mismatch("heading_valid", 16'(m_tuser[0]), 16'(e.valid));
                if (m_tuser[1] !== e.held)
                    report_mismatch("sample_held", 16'(m_tuser[1]), 16'(e.held));
                if (m_tuser[2] !== e.hreset)
                    report_mismatch("history_reset", 16'(m_tuser[2]), 16'(e.hreset));
            end
        end
    end

    // receiver stalls
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 0;
                repeat (600) @(negedge aclk);
                hold_req = 0;
            end
            m_tready = ($urandom_range(99) >= snk_idle);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        vec_t dir [$];
        heading_res_t none;
        heading_res_t r;
        logic [15:0] base, spd, hdg;
        logic [1:0] op;
        int n, sel;

        none = '{mean: 16'd0, valid: 0, held: 0, hreset: 0};
        reset_model();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // after reset: nothing valid; stop flags the clear
        dir.push_back('{OP_START, 16'd0, 16'd0, 1, none});
        dir.push_back('{OP_STOP, 16'd0, 16'd0, 1, '{16'd0, 0, 0, 1}});
        dir.push_back('{OP_NONE, 16'hFFFF, 16'hFFFF, 1, none});
        dir.push_back('{OP_SAMPLE, 16'd0, 16'h1234, 1, none});
        dir.push_back('{OP_SAMPLE, 16'd1, 16'h4000, 0, none});
        dir.push_back('{OP_SAMPLE, 16'd256, 16'd0, 0, none});
        dir.push_back('{OP_SAMPLE, 16'h7FFF, 16'hFFFF, 0, none});
        dir.push_back('{OP_SAMPLE, 16'h8000, 16'h8000, 0, none});
        dir.push_back('{OP_SAMPLE, 16'd512, 16'h4000, 0, none});
        dir.push_back('{OP_SAMPLE, 16'd512, 16'hC000, 0, none});
        dir.push_back('{OP_SAMPLE, 16'd0, 16'd0, 0, none});
        dir.push_back('{OP_SAMPLE, 16'd2, 16'h2000, 0, none});
        for (int i = 0; i < 6; i++)
            dir.push_back('{OP_SAMPLE, 16'd800, 16'h8000 + 16'(i * 64), 0, none});
        dir.push_back('{OP_NONE, 16'd0, 16'd0, 0, none});
        dir.push_back('{OP_STOP, 16'd0, 16'd0, 0, none});
        dir.push_back('{OP_SAMPLE, 16'd800, 16'h0000, 0, none});
        dir.push_back('{OP_START, 16'd0, 16'd0, 0, none});
        dir.push_back('{OP_SAMPLE, 16'hFF00, 16'h0100, 0, none});
        foreach (dir[i]) send_item(dir[i].op, dir[i].speed, dir[i].hdg, dir[i].typed, dir[i].res);

        base = 16'h0;
        for (int ph = 0; ph < 6; ph++) begin
            @(negedge aclk);
            s_tvalid = 0;
            wait_idle();
            case (ph)
                0: begin
                    write_reg(REG_OUTLIER_THR, OUTLIER_THR_RST);
                    hold_req = 1;
                end
                1: begin
                    write_reg(REG_OUTLIER_THR, 16'd0);
                    write_reg(REG_OUTLIER_LIM, 16'd0);
                    write_reg(REG_LOW_SPEED, 16'd0);
                end
                2: begin
                    write_reg(REG_OUTLIER_THR, 16'd32768);
                    write_reg(REG_OUTLIER_LIM, 16'd14);
                    write_reg(REG_LOW_SPEED, 16'd32767);
                end
                3: begin
                    write_reg(REG_OUTLIER_THR, 16'd1500);
                    write_reg(REG_OUTLIER_LIM, 16'd1);
                    write_reg(REG_LOW_SPEED, 16'd20);
                end
                4: begin
                    write_reg(REG_OUTLIER_THR, 16'($urandom_range(32768)));
                    write_reg(REG_OUTLIER_LIM, 16'($urandom_range(14)));
                    write_reg(REG_LOW_SPEED, 16'($urandom_range(300)));
                end
                default: begin
                    write_reg(REG_OUTLIER_THR, 16'd6000);
                    write_reg(REG_OUTLIER_LIM, 16'd5);
                    write_reg(REG_LOW_SPEED, 16'd8);
                end
            endcase
            case (ph / 2)
                0: begin src_idle = 18; snk_idle = 77; end
                1: begin src_idle = 77; snk_idle = 18; end
                default: begin src_idle = 0; snk_idle = 0; end
            endcase
            n = RAND_ITEMS / 6;
            for (int k = 0; k < n; k++) begin
                sel = $urandom_range(99);
                op = (sel < 85) ? OP_SAMPLE : (sel < 90) ? OP_START :
                     (sel < 95) ? OP_STOP : OP_NONE;
                if ($urandom_range(99) < 10) base = 16'($urandom);
                hdg = base + 16'($signed($urandom_range(4000)) - 2000);
                sel = $urandom_range(99);
                if (sel < 55) spd = 16'($urandom_range(8000, 200));
                else if (sel < 65) spd = -16'($urandom_range(8000, 200));
                else if (sel < 80) spd = 16'($signed($urandom_range(16)) - 8);
                else spd = 16'($urandom);
                if ($urandom_range(99) < 10) hdg = 16'($urandom);
                send_item(op, spd, hdg, 0, none);
            end
        end
        @(negedge aclk);
        s_tvalid = 0;
        wait_idle();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
